// File: hw/rtl/htv_pkg.sv
// Shared types, constants and fixed-point helpers for the helix tube vertex generator.
// No dependencies; imported by htv_coef, the top level, the checker and the testbench.
package htv_pkg;

  localparam int DEF_FRAC_BITS       = 16;
  localparam int DEF_TRIG_TABLE_BITS = 10;
  localparam int CFG_W               = 24;
  localparam int POS_W               = 27;
  localparam int NORM_W              = 16;
  localparam int PADDR_W             = 4;

  localparam logic [1:0] REG_COIL_RADIUS       = 2'd0;
  localparam logic [1:0] REG_HELIX_HALF_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TUBE_RADIUS       = 2'd2;
  localparam logic [1:0] REG_TURN_RATE         = 2'd3;

  localparam logic [CFG_W-1:0] RST_COIL_RADIUS       = 24'd65536;
  localparam logic [CFG_W-1:0] RST_HELIX_HALF_HEIGHT = 24'd65536;
  localparam logic [CFG_W-1:0] RST_TUBE_RADIUS       = 24'd16384;
  localparam logic [CFG_W-1:0] RST_TURN_RATE         = 24'd65536;

  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [63:0] SC1  = 64'd1686629713;
  localparam logic [63:0] SC3  = 64'd693598669;
  localparam logic [63:0] SC5  = 64'd85569306;
  localparam logic [63:0] SC7  = 64'd5026995;
  localparam logic [63:0] SC9  = 64'd172272;
  localparam logic [63:0] SC11 = 64'd3864;
  localparam logic [63:0] ONE30 = 64'd1 << 30;

  typedef enum logic [3:0] {
    CS_IDLE, CS_MUL1, CS_MUL2, CS_GSUM, CS_DIVH,
    CS_SQI, CS_SQRT, CS_DIVW, CS_DIVHW, CS_FIN
  } coef_state_t;

  // quarter-wave sine, Q30 in and out
  function automatic logic [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    x2 = (x * x) >> 30;
    p = SC11;
    p = SC9 - ((p * x2) >> 30);
    p = SC7 - ((p * x2) >> 30);
    p = SC5 - ((p * x2) >> 30);
    p = SC3 - ((p * x2) >> 30);
    p = SC1 - ((p * x2) >> 30);
    p = (p * x) >> 30;
    return (p > ONE30) ? ONE30 : p;
  endfunction

  // shift right, round half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p, input int sh);
    logic [63:0] mag;
    logic [63:0] half;
    mag = p[63] ? 64'(-p) : 64'(p);
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    mag = (mag + half) >> sh;
    return p[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// File: hw/rtl/helix_tube_vertex_generator_top.sv
// Helix tube vertex generator, top level: config registers and the vertex pipeline.
// Uses htv_pkg and htv_coef.
//
//   channel   direction  handshake               word
//   input     in         in_valid / in_stall     coord_u, coord_v
//   output    out        out_valid / out_stall   pos_x..z, norm_x..z, bad_config
//   config    in         APB psel/penable        coil_radius .. turn_rate
//
// One word per cycle, while in_stall is low, through nine register stages; out_valid is
// registered alongside the stage 9 output word.
// After reset and after every register write the coefficient sequencer runs a square root
// plus two or three 64-step divisions; in_stall stays high while it runs.
// A stalled output word freezes every stage at once; in_stall rises in the same cycle.
module helix_tube_vertex_generator_top #(
  parameter int FRAC_BITS       = htv_pkg::DEF_FRAC_BITS,
  parameter int TRIG_TABLE_BITS = htv_pkg::DEF_TRIG_TABLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [16:0]                        coord_u,
  input  logic [16:0]                        coord_v,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [htv_pkg::POS_W-1:0]   pos_x,
  output logic signed [htv_pkg::POS_W-1:0]   pos_y,
  output logic signed [htv_pkg::POS_W-1:0]   pos_z,
  output logic signed [htv_pkg::NORM_W-1:0]  norm_x,
  output logic signed [htv_pkg::NORM_W-1:0]  norm_y,
  output logic signed [htv_pkg::NORM_W-1:0]  norm_z,
  output logic                               bad_config,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [htv_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import htv_pkg::*;

  localparam int TW      = FRAC_BITS + 2;
  localparam int NW      = TW + 1;
  localparam int AW      = TRIG_TABLE_BITS - 1;
  localparam int QUARTER = 1 << (TRIG_TABLE_BITS - 2);
  localparam int NQ      = QUARTER + 1;
  localparam int BW      = 26;
  localparam int PYW     = 27;
  localparam int QR      = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int QL      = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam logic signed [63:0] PMAX = 64'sd67108863;
  localparam logic signed [63:0] PMIN = -64'sd67108864;

  typedef logic [FRAC_BITS:0] rom_t [NQ];
  typedef struct packed {
    logic          neg;
    logic [AW-1:0] addr;
  } taddr_t;

  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] v;
    for (int k = 0; k < NQ; k++) begin
      v = quarter_sine(64'(k) << (30 - (TRIG_TABLE_BITS - 2)));
      tab[k] = (FRAC_BITS + 1)'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic taddr_t trig_addr(input logic [31:0] ph);
    logic [TRIG_TABLE_BITS+1:0] w;
    logic [TRIG_TABLE_BITS-1:0] i;
    logic [TRIG_TABLE_BITS-3:0] j;
    taddr_t                     o;
    w = {1'b0, ph[31:31-TRIG_TABLE_BITS]} + (TRIG_TABLE_BITS + 2)'(1);
    i = w[TRIG_TABLE_BITS:1];
    j = i[TRIG_TABLE_BITS-3:0];
    o.neg = i[TRIG_TABLE_BITS-1];
    o.addr = i[TRIG_TABLE_BITS-2] ? AW'(QUARTER) - AW'(j) : AW'(j);
    return o;
  endfunction

  function automatic logic signed [TW-1:0] apply_sign(input logic [FRAC_BITS:0] v,
                                                      input logic neg);
    logic signed [TW-1:0] s;
    s = $signed({1'b0, v});
    return neg ? -s : s;
  endfunction

  function automatic logic signed [NORM_W-1:0] to_q15(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = (FRAC_BITS >= 15) ? rnd_shift(x, QR) : (x <<< QL);
    if (y > 64'sd32767) y = 64'sd32767;
    if (y < -64'sd32768) y = -64'sd32768;
    return y[NORM_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (y > PMAX) y = PMAX;
    if (y < PMIN) y = PMIN;
    return y[POS_W-1:0];
  endfunction

  // config registers
  logic [CFG_W-1:0] coil_radius;
  logic [CFG_W-1:0] helix_half_height;
  logic [CFG_W-1:0] tube_radius;
  logic [CFG_W-1:0] turn_rate;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coil_radius       <= RST_COIL_RADIUS;
      helix_half_height <= RST_HELIX_HALF_HEIGHT;
      tube_radius       <= RST_TUBE_RADIUS;
      turn_rate         <= RST_TURN_RATE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_COIL_RADIUS:       coil_radius       <= pwdata[CFG_W-1:0];
        REG_HELIX_HALF_HEIGHT: helix_half_height <= pwdata[CFG_W-1:0];
        REG_TUBE_RADIUS:       tube_radius       <= pwdata[CFG_W-1:0];
        REG_TURN_RATE:         turn_rate         <= pwdata[CFG_W-1:0];
        default:               coil_radius       <= coil_radius;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COIL_RADIUS:       prdata = 32'(coil_radius);
      REG_HELIX_HALF_HEIGHT: prdata = 32'(helix_half_height);
      REG_TUBE_RADIUS:       prdata = 32'(tube_radius);
      REG_TURN_RATE:         prdata = 32'(turn_rate);
      default:               prdata = '0;
    endcase
  end

  logic                 coef_busy;
  logic [FRAC_BITS:0]   sk;
  logic [FRAC_BITS:0]   ik;

  htv_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_wr),
    .coil_radius (coil_radius),
    .turn_rate   (turn_rate),
    .busy        (coef_busy),
    .sk          (sk),
    .ik          (ik)
  );

  // pipeline control
  logic       en;
  logic [8:1] vld;
  logic       ov;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en || coef_busy;
  assign out_valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      ov  <= 1'b0;
    end else if (en) begin
      vld <= {vld[7:1], in_valid && !coef_busy};
      ov  <= vld[8];
    end
  end

  // stage 1
  logic signed [18:0]  vp_c;
  logic [16:0]         ub_c;
  logic signed [43:0]  s1_vph;
  logic [31:0]         s1_phb;

  assign vp_c = $signed({1'b0, coord_v, 1'b0}) - 19'sd65536;
  assign ub_c = 17'd65536 - coord_u;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vph <= vp_c * $signed({1'b0, helix_half_height});
      s1_phb <= {ub_c[15:0], 16'b0};
    end
  end

  // stage 2
  logic [47:0]          s2_palo;
  logic [47:0]          s2_pahi;
  logic signed [PYW-1:0] s2_pyb;
  logic [31:0]          s2_phb;
  logic signed [56:0]   palo_c;
  logic signed [56:0]   pahi_c;

  assign palo_c = s1_vph * $signed({1'b0, turn_rate[11:0]});
  assign pahi_c = s1_vph * $signed({1'b0, turn_rate[23:12]});

  always_ff @(posedge clk) begin
    if (en) begin
      s2_palo <= palo_c[47:0];
      s2_pahi <= pahi_c[47:0];
      s2_pyb  <= PYW'(rnd_shift(64'(s1_vph), 16));
      s2_phb  <= s1_phb;
    end
  end

  // stage 3: phase, table read
  logic [47:0]           pa_c;
  logic [31:0]           pha_c;
  taddr_t                ad_sa, ad_ca, ad_sb, ad_cb;
  logic [FRAC_BITS:0]    s3_sa, s3_ca, s3_sb, s3_cb;
  logic                  s3_nsa, s3_nca, s3_nsb, s3_ncb;
  logic signed [PYW-1:0] s3_pyb;

  assign pa_c  = s2_palo + (s2_pahi << 12);
  assign pha_c = pa_c[47:16];
  assign ad_sa = trig_addr(pha_c);
  assign ad_ca = trig_addr(pha_c + 32'h4000_0000);
  assign ad_sb = trig_addr(s2_phb);
  assign ad_cb = trig_addr(s2_phb + 32'h4000_0000);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sa  <= SINE_ROM[ad_sa.addr];
      s3_ca  <= SINE_ROM[ad_ca.addr];
      s3_sb  <= SINE_ROM[ad_sb.addr];
      s3_cb  <= SINE_ROM[ad_cb.addr];
      s3_nsa <= ad_sa.neg;
      s3_nca <= ad_ca.neg;
      s3_nsb <= ad_sb.neg;
      s3_ncb <= ad_cb.neg;
      s3_pyb <= s2_pyb;
    end
  end

  // stage 4: first products
  logic signed [TW-1:0]     sa_c, ca_c, sb_c, cb_c;
  logic signed [2*TW-1:0]   p_cbsa, p_cbca, p_sbsk, p_sbik;
  logic signed [TW+24:0]    p_rsa, p_rca;
  logic signed [TW-1:0]     s4_sa, s4_ca;
  logic signed [PYW-1:0]    s4_pyb;

  assign sa_c = apply_sign(s3_sa, s3_nsa);
  assign ca_c = apply_sign(s3_ca, s3_nca);
  assign sb_c = apply_sign(s3_sb, s3_nsb);
  assign cb_c = apply_sign(s3_cb, s3_ncb);

  always_ff @(posedge clk) begin
    if (en) begin
      p_cbsa <= cb_c * sa_c;
      p_cbca <= cb_c * ca_c;
      p_sbsk <= sb_c * $signed({1'b0, sk});
      p_sbik <= sb_c * $signed({1'b0, ik});
      p_rsa  <= $signed({1'b0, coil_radius}) * sa_c;
      p_rca  <= $signed({1'b0, coil_radius}) * ca_c;
      s4_sa  <= sa_c;
      s4_ca  <= ca_c;
      s4_pyb <= s3_pyb;
    end
  end

  // stage 5: round first products
  logic signed [TW-1:0]  s5_t, s5_ny, s5_a1, s5_a2, s5_sa, s5_ca;
  logic signed [BW-1:0]  s5_b1, s5_b2;
  logic signed [PYW-1:0] s5_pyb;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t   <= TW'(rnd_shift(64'(p_sbsk), FRAC_BITS));
      s5_ny  <= TW'(-rnd_shift(64'(p_sbik), FRAC_BITS));
      s5_a1  <= TW'(rnd_shift(64'(p_cbsa), FRAC_BITS));
      s5_a2  <= TW'(rnd_shift(64'(p_cbca), FRAC_BITS));
      s5_b1  <= BW'(rnd_shift(64'(p_rsa), FRAC_BITS));
      s5_b2  <= BW'(rnd_shift(64'(p_rca), FRAC_BITS));
      s5_sa  <= s4_sa;
      s5_ca  <= s4_ca;
      s5_pyb <= s4_pyb;
    end
  end

  // stage 6: tangent terms
  logic signed [2*TW-1:0] p_tca, p_tsa;
  logic signed [TW-1:0]   s6_ny, s6_a1, s6_a2;
  logic signed [BW-1:0]   s6_b1, s6_b2;
  logic signed [PYW-1:0]  s6_pyb;

  always_ff @(posedge clk) begin
    if (en) begin
      p_tca  <= s5_t * s5_ca;
      p_tsa  <= s5_t * s5_sa;
      s6_ny  <= s5_ny;
      s6_a1  <= s5_a1;
      s6_a2  <= s5_a2;
      s6_b1  <= s5_b1;
      s6_b2  <= s5_b2;
      s6_pyb <= s5_pyb;
    end
  end

  // stage 7: normal
  logic signed [NW-1:0]  s7_nx, s7_ny, s7_nz;
  logic signed [BW-1:0]  s7_b1, s7_b2;
  logic signed [PYW-1:0] s7_pyb;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nx  <= NW'(64'(s6_a1) + rnd_shift(64'(p_tca), FRAC_BITS));
      s7_nz  <= NW'(64'(s6_a2) - rnd_shift(64'(p_tsa), FRAC_BITS));
      s7_ny  <= NW'(s6_ny);
      s7_b1  <= s6_b1;
      s7_b2  <= s6_b2;
      s7_pyb <= s6_pyb;
    end
  end

  // stage 8: tube offset products
  logic signed [NW+24:0] p_rnx, p_rny, p_rnz;
  logic signed [NW-1:0]  s8_nx, s8_ny, s8_nz;
  logic signed [BW-1:0]  s8_b1, s8_b2;
  logic signed [PYW-1:0] s8_pyb;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rnx  <= $signed({1'b0, tube_radius}) * s7_nx;
      p_rny  <= $signed({1'b0, tube_radius}) * s7_ny;
      p_rnz  <= $signed({1'b0, tube_radius}) * s7_nz;
      s8_nx  <= s7_nx;
      s8_ny  <= s7_ny;
      s8_nz  <= s7_nz;
      s8_b1  <= s7_b1;
      s8_b2  <= s7_b2;
      s8_pyb <= s7_pyb;
    end
  end

  // stage 9: output register
  logic bad_c;
  assign bad_c = (coil_radius == '0) || (turn_rate == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (bad_c) begin
        pos_x      <= '0;
        pos_y      <= '0;
        pos_z      <= '0;
        norm_x     <= '0;
        norm_y     <= '0;
        norm_z     <= '0;
        bad_config <= 1'b1;
      end else begin
        pos_x      <= sat_pos(64'(s8_b1) + rnd_shift(64'(p_rnx), FRAC_BITS));
        pos_y      <= sat_pos(64'(s8_pyb) + rnd_shift(64'(p_rny), FRAC_BITS));
        pos_z      <= sat_pos(64'(s8_b2) + rnd_shift(64'(p_rnz), FRAC_BITS));
        norm_x     <= to_q15(64'(s8_nx));
        norm_y     <= to_q15(64'(s8_ny));
        norm_z     <= to_q15(64'(s8_nz));
        bad_config <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/htv_coef.sv
// Frame coefficient sequencer: derives s/k and 1/k from helix radius and loops.
// Uses htv_pkg; shared restoring divider and bit-pair integer square root.
module htv_coef #(
  parameter int FRAC_BITS = htv_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [htv_pkg::CFG_W-1:0]   coil_radius,
  input  logic [htv_pkg::CFG_W-1:0]   turn_rate,
  output logic                        busy,
  output logic [FRAC_BITS:0]          sk,
  output logic [FRAC_BITS:0]          ik
);
  import htv_pkg::*;

  coef_state_t state, state_next;

  logic [47:0] rl;
  logic [63:0] hip;
  logic [47:0] plo;
  logic        big;
  logic [30:0] h30;
  logic [30:0] sq;
  logic [30:0] w30;
  logic [30:0] hw30;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [63:0] dvs;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [63:0] m;
  logic [63:0] sr;
  logic [63:0] sbit;

  logic [64:0] rem_sh;
  logic        ge;
  logic [64:0] rem_nx;
  logic [63:0] quo_nx;
  logic [63:0] ssum;
  logic        sge;
  logic [63:0] m_nx;
  logic [63:0] r_nx;
  logic [48:0] lo_c;
  logic [51:0] g_c;
  logic [61:0] hsq;
  logic [31:0] ksel;

  assign rem_sh = {rem[63:0], dvd[63]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign rem_nx = ge ? rem_sh - {1'b0, dvs} : rem_sh;
  assign quo_nx = {quo[62:0], ge};
  assign ssum   = sr + sbit;
  assign sge    = m >= ssum;
  assign m_nx   = sge ? m - ssum : m;
  assign r_nx   = sge ? (sr >> 1) + sbit : sr >> 1;
  assign lo_c   = 49'({hip[12:0], 16'b0}) + 49'(plo);
  assign g_c    = 52'(hip >> 13) + 52'(lo_c >> 29);
  assign hsq    = h30 * h30;
  assign ksel   = {1'b0, (big ? hw30 : w30)} + (32'd1 << (29 - FRAC_BITS));
  assign busy   = state != CS_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_MUL1;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE:  state_next = CS_IDLE;
      CS_MUL1:  state_next = CS_MUL2;
      CS_MUL2:  state_next = CS_GSUM;
      CS_GSUM:  state_next = (g_c >= 52'h1_0000_0000) ? CS_DIVH : CS_SQI;
      CS_DIVH:  state_next = (cnt == 6'd63) ? CS_SQI : CS_DIVH;
      CS_SQI:   state_next = CS_SQRT;
      CS_SQRT:  state_next = (cnt == 6'd31) ? CS_DIVW : CS_SQRT;
      CS_DIVW:  state_next = (cnt == 6'd63) ? CS_DIVHW : CS_DIVW;
      CS_DIVHW: state_next = (cnt == 6'd63) ? CS_FIN : CS_DIVHW;
      CS_FIN:   state_next = CS_IDLE;
      default:  state_next = CS_MUL1;
    endcase
    if (restart) state_next = CS_MUL1;
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_MUL1: begin
        rl <= coil_radius * turn_rate;
      end
      CS_MUL2: begin
        hip <= 64'(rl[47:16]) * 64'(TWO_PI_Q29);
        plo <= 48'(rl[15:0]) * 48'(TWO_PI_Q29);
      end
      CS_GSUM: begin
        big <= g_c >= 52'h1_0000_0000;
        h30 <= (g_c == '0) ? '0 : 31'((g_c + 52'd2) >> 2);
        dvd <= (64'd1 << 62) + 64'(g_c >> 1);
        dvs <= 64'(g_c);
        rem <= '0;
        cnt <= '0;
      end
      CS_DIVH: begin
        rem <= rem_nx;
        quo <= quo_nx;
        dvd <= dvd << 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) h30 <= quo_nx[30:0];
      end
      CS_SQI: begin
        m    <= (64'd1 << 60) + 64'(hsq);
        sr   <= '0;
        sbit <= 64'd1 << 62;
        cnt  <= '0;
      end
      CS_SQRT: begin
        m    <= m_nx;
        sr   <= r_nx;
        sbit <= sbit >> 2;
        if (cnt == 6'd31) begin
          sq  <= r_nx[30:0];
          dvd <= (64'd1 << 60) + (r_nx >> 1);
          dvs <= r_nx;
          rem <= '0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      CS_DIVW: begin
        quo <= quo_nx;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          w30 <= quo_nx[30:0];
          dvd <= (64'(h30) << 30) + 64'(sq >> 1);
          dvs <= 64'(sq);
          rem <= '0;
        end else begin
          rem <= rem_nx;
          dvd <= dvd << 1;
        end
      end
      CS_DIVHW: begin
        rem <= rem_nx;
        quo <= quo_nx;
        dvd <= dvd << 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) hw30 <= quo_nx[30:0];
      end
      CS_FIN: begin
        sk <= (FRAC_BITS + 1)'(ksel >> (30 - FRAC_BITS));
        ik <= (FRAC_BITS + 1)'(({1'b0, (big ? w30 : hw30)} + (32'd1 << (29 - FRAC_BITS)))
              >> (30 - FRAC_BITS));
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// File: hw/rtl/htv_check.sv
// Port-level checker for the helix tube vertex generator, bound to the top level.
// Uses htv_pkg for field widths.
module htv_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [htv_pkg::POS_W-1:0]   pos_x,
  input logic signed [htv_pkg::POS_W-1:0]   pos_y,
  input logic signed [htv_pkg::POS_W-1:0]   pos_z,
  input logic signed [htv_pkg::NORM_W-1:0]  norm_x,
  input logic signed [htv_pkg::NORM_W-1:0]  norm_y,
  input logic signed [htv_pkg::NORM_W-1:0]  norm_z,
  input logic                               bad_config,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite
);
  import htv_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped under stall");

  // flagged words carry zero payload
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_config |-> pos_x == 0 && pos_y == 0 && pos_z == 0 &&
      norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("flagged word has nonzero payload");

  // stall input while coefficients are rebuilt after reset
  a_rst_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open right after reset");

  // stall input after a register write
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> in_stall)
    else $error("input open right after register write");

  // a stalled output also stalls input
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

endmodule

bind helix_tube_vertex_generator_top htv_check u_htv_check (.*);

// File: tb/tb.sv
// Self-checking testbench for helix_tube_vertex_generator_top: streams (u, v) words,
// predicts each vertex with a fixed-point model of its own and checks every result word.
// Depends on htv_pkg and the RTL top level only.
module tb;
  import htv_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic                     bad;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [16:0] coord_u = '0, coord_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
  logic bad_config;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [CFG_W-1:0] helix_r, half_h, tube_r, loops;
  vertex_t pending_vertices[$];
  int fails = 0;
  int stall_free = 0;
  int quiet_cycles = 0;

  helix_tube_vertex_generator_top u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint round_mul(longint a, longint b, int sh);
    bit [63:0] m;
    bit neg;
    neg = (a < 0) != (b < 0);
    m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic bit [63:0] poly_sine(bit [63:0] x);
    bit [63:0] x2, p;
    x2 = (x * x) >> 30;
    p = SC11;
    p = SC9 - ((p * x2) >> 30);
    p = SC7 - ((p * x2) >> 30);
    p = SC5 - ((p * x2) >> 30);
    p = SC3 - ((p * x2) >> 30);
    p = SC1 - ((p * x2) >> 30);
    p = (p * x) >> 30;
    return p > ONE30 ? ONE30 : p;
  endfunction

  // sine of a turn fraction, rounded to the table grid, Q(FRAC) result
  function automatic longint phase_sine(bit [31:0] ph);
    bit [31:0] i, q;
    bit [63:0] x, s;
    i = (((ph >> (31 - DEF_TRIG_TABLE_BITS)) + 1) >> 1) & ((1 << DEF_TRIG_TABLE_BITS) - 1);
    q = i >> (DEF_TRIG_TABLE_BITS - 2);
    x = 64'(i & ((1 << (DEF_TRIG_TABLE_BITS - 2)) - 1)) << (30 - (DEF_TRIG_TABLE_BITS - 2));
    if (q[0]) x = ONE30 - x;
    s = poly_sine(x);
    return round_mul(q[1] ? -longint'(s) : longint'(s), 1, 30 - DEF_FRAC_BITS);
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] m);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > m) b >>= 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vertex_t predict_vertex(bit [16:0] u, bit [16:0] v);
    vertex_t e;
    longint vp, sa, ca, sb, cb, sk, ik, t, nx, ny, nz, px, py, pz, plim;
    bit [63:0] rl, hip, g, h30, sq, w30, hw30;
    bit [31:0] pha, phb;
    bit big;
    e = '0;
    plim = (longint'(1) << 26) - 1;
    if (helix_r == 0 || loops == 0) begin
      e.bad = 1'b1;
      return e;
    end
    vp = 2 * longint'(v) - 65536;
    pha = 32'((64'(vp) * 64'(half_h) * 64'(loops)) >> 16);
    phb = ((32'd65536 - u) & 32'hFFFF) << 16;
    sa = phase_sine(pha);
    ca = phase_sine(pha + 32'h4000_0000);
    sb = phase_sine(phb);
    cb = phase_sine(phb + 32'h4000_0000);
    rl = 64'(helix_r) * 64'(loops);
    hip = (rl >> 16) * 64'(TWO_PI_Q29);
    g = (hip >> 13) + ((((hip & 64'h1FFF) << 16) + (rl & 64'hFFFF) * 64'(TWO_PI_Q29)) >> 29);
    big = g >= (64'd1 << 32);
    if (g == 0) h30 = 0;
    else if (!big) h30 = (g + 2) >> 2;
    else h30 = ((64'd1 << 62) + g / 2) / g;
    sq = floor_sqrt((64'd1 << 60) + h30 * h30);
    w30 = ((64'd1 << 60) + sq / 2) / sq;
    hw30 = ((h30 << 30) + sq / 2) / sq;
    sk = round_mul(longint'(big ? hw30 : w30), 1, 30 - DEF_FRAC_BITS);
    ik = round_mul(longint'(big ? w30 : hw30), 1, 30 - DEF_FRAC_BITS);
    t = round_mul(sb, sk, DEF_FRAC_BITS);
    nx = round_mul(cb, sa, DEF_FRAC_BITS) + round_mul(t, ca, DEF_FRAC_BITS);
    ny = -round_mul(sb, ik, DEF_FRAC_BITS);
    nz = round_mul(cb, ca, DEF_FRAC_BITS) - round_mul(t, sa, DEF_FRAC_BITS);
    px = round_mul(helix_r, sa, DEF_FRAC_BITS) + round_mul(tube_r, nx, DEF_FRAC_BITS);
    py = round_mul(vp, half_h, 16) + round_mul(tube_r, ny, DEF_FRAC_BITS);
    pz = round_mul(helix_r, ca, DEF_FRAC_BITS) + round_mul(tube_r, nz, DEF_FRAC_BITS);
    e.px = POS_W'(clip(px, -plim - 1, plim));
    e.py = POS_W'(clip(py, -plim - 1, plim));
    e.pz = POS_W'(clip(pz, -plim - 1, plim));
    e.nx = NORM_W'(clip(round_mul(nx, 1, DEF_FRAC_BITS - 15), -32768, 32767));
    e.ny = NORM_W'(clip(round_mul(ny, 1, DEF_FRAC_BITS - 15), -32768, 32767));
    e.nz = NORM_W'(clip(round_mul(nz, 1, DEF_FRAC_BITS - 15), -32768, 32767));
    return e;
  endfunction

  task automatic send_word(bit [16:0] u, bit [16:0] v);
    while (!stall_free && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_u <= u;
    coord_v <= v;
    do @(posedge clk); while (in_stall);
    pending_vertices.push_back(predict_vertex(u, v));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_COIL_RADIUS:       helix_r = value[CFG_W-1:0];
      REG_HELIX_HALF_HEIGHT: half_h = value[CFG_W-1:0];
      REG_TUBE_RADIUS:       tube_r = value[CFG_W-1:0];
      default:               loops = value[CFG_W-1:0];
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {8'd0, value[CFG_W-1:0]}) begin
      $display("%0t readback reg %0d: expected %h actual %h", $time, idx,
               {8'd0, value[CFG_W-1:0]}, prdata);
      fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_helix(logic [23:0] r_big, logic [23:0] h, logic [23:0] r_tube,
                           logic [23:0] l);
    write_reg(REG_COIL_RADIUS, {8'($urandom_range(255)), r_big});
    write_reg(REG_HELIX_HALF_HEIGHT, {8'($urandom_range(255)), h});
    write_reg(REG_TUBE_RADIUS, {8'($urandom_range(255)), r_tube});
    write_reg(REG_TURN_RATE, {8'($urandom_range(255)), l});
  endtask

  function automatic bit [16:0] rand_coord();
    return ($urandom_range(99) < 80) ? 17'($urandom_range(65536)) : 17'($urandom_range(131071));
  endfunction

  task automatic test_coord_extremes();
    bit [16:0] edges[5] = '{17'd0, 17'd1, 17'd32768, 17'd65536, 17'd131071};
    foreach (edges[i]) foreach (edges[j]) send_word(edges[i], edges[j]);
  endtask

  task automatic test_bad_config();
    set_helix(24'd0, 24'd65536, 24'd16384, 24'd65536);
    send_word(17'd100, 17'd40000);
    set_helix(24'd65536, 24'd65536, 24'd16384, 24'd0);
    send_word(17'd65536, 17'd0);
  endtask

  task automatic test_config_extremes();
    set_helix(24'd1, 24'd1, 24'd0, 24'd1);
    send_word(17'd16384, 17'd65536);
    send_word(17'd50000, 17'd3);
    set_helix(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(17'd0, 17'd131071);
    send_word(17'd12345, 17'd0);
  endtask

  task automatic test_random_helices();
    for (int phase = 0; phase < 6; phase++) begin
      stall_free = (phase == 2);
      case (phase)
        0: set_helix(24'd65536, 24'd65536, 24'd16384, 24'd65536);
        1: set_helix(24'($urandom_range(255)), 24'($urandom), 24'($urandom_range(65535)),
                     24'($urandom_range(255)));
        default: set_helix(24'($urandom), 24'($urandom_range(1 << 20)),
                           24'($urandom_range(1 << 18)), 24'($urandom_range(1 << 19)));
      endcase
      repeat (120) send_word(rand_coord(), rand_coord());
    end
    stall_free = 0;
  endtask

  always @(posedge clk) begin
    vertex_t e, got;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, bad_config};
      if (pending_vertices.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        fails++;
      end else begin
        e = pending_vertices.pop_front();
        if (got.px !== e.px) $display("%0t pos_x expected %0d actual %0d", $time, e.px, got.px);
        if (got.py !== e.py) $display("%0t pos_y expected %0d actual %0d", $time, e.py, got.py);
        if (got.pz !== e.pz) $display("%0t pos_z expected %0d actual %0d", $time, e.pz, got.pz);
        if (got.nx !== e.nx) $display("%0t norm_x expected %0d actual %0d", $time, e.nx, got.nx);
        if (got.ny !== e.ny) $display("%0t norm_y expected %0d actual %0d", $time, e.ny, got.ny);
        if (got.nz !== e.nz) $display("%0t norm_z expected %0d actual %0d", $time, e.nz, got.nz);
        if (got.bad !== e.bad)
          $display("%0t bad_config expected %b actual %b", $time, e.bad, got.bad);
        if (got !== e) fails++;
      end
    end
    out_stall <= !stall_free && ($urandom_range(99) < 11);
  end

  initial begin
    helix_r = RST_COIL_RADIUS;
    half_h = RST_HELIX_HALF_HEIGHT;
    tube_r = RST_TUBE_RADIUS;
    loops = RST_TURN_RATE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_coord_extremes();
    drain();
    test_bad_config();
    test_config_extremes();
    test_random_helices();
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
